[hdl/assert_macros.svh]
// assertion macros used by the command interpreter result buffer module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define VGM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define VGM_ASSERT_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define VGM_ASSERT(lbl, clk, rst_n, prop)
`define VGM_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

[hdl/vgmci_pkg.sv]
// types, constants and muting functions of the vgm command interpreter
`timescale 1ns / 1ps
package vgmci_pkg;

    localparam int MAX_RES  = 12;
    localparam int CNT_W    = $clog2(MAX_RES + 1);
    localparam int MUTE_LEN = 10;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] PAN_SIDES = 8'hC0;
    localparam logic [7:0] PAN_KEEP  = 8'h3F;
    localparam logic [7:0] PSG_OFF   = 8'h9F;
    localparam logic [7:0] PSG_ATT   = 8'h90;
    localparam logic [7:0] REG_PAN1  = 8'hB4;
    localparam logic [7:0] REG_PAN3  = 8'hB6;
    localparam logic [7:0] REG_DACEN = 8'h2B;
    localparam logic [7:0] REG_DAC   = 8'h2A;
    localparam logic [15:0] WAIT_NTSC = 16'd735;
    localparam logic [15:0] WAIT_PAL  = 16'd882;

    localparam logic [7:0] OP_PSG      = 8'h50;
    localparam logic [7:0] OP_FM0      = 8'h52;
    localparam logic [7:0] OP_FM1      = 8'h53;
    localparam logic [7:0] OP_WAIT     = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL = 8'h63;
    localparam logic [7:0] OP_END      = 8'h66;
    localparam logic [7:0] OP_GG       = 8'h4F;
    localparam logic [7:0] OP_PWM      = 8'hB2;
    localparam logic [3:0] OP_HI_WAITN = 4'h7;
    localparam logic [3:0] OP_HI_DACW  = 4'h8;
    localparam logic [7:0] OP_STRM_LO  = 8'h90;
    localparam logic [7:0] OP_STRM_HI  = 8'h95;

    localparam logic [7:0] PAN_ADDR [6] = '{8'hB4, 8'hB5, 8'hB6, 8'hB4, 8'hB5, 8'hB6};

    typedef enum logic [1:0] {
        ACT_CMD     = 2'd0,
        ACT_START   = 2'd1,
        ACT_REFRESH = 2'd2,
        ACT_SILENCE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_PSG     = 3'd0,
        KIND_FM      = 3'd1,
        KIND_WAIT    = 3'd2,
        KIND_RESET   = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FM_MASK  = 3'd0,
        CFG_PSG_MASK = 3'd1,
        CFG_FIX_PSG  = 3'd2,
        CFG_MIT_TRIM = 3'd3,
        CFG_MONO     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_action    action;
        logic [7:0] opcode;
        logic [7:0] data_lo;
        logic [7:0] data_hi;
        logic [7:0] pcm_sample;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic        fm_port;
        logic [7:0]  address;
        logic [7:0]  value;
        logic [15:0] wait_samples;
        logic        last;
    } t_res;

    typedef t_res [MAX_RES-1:0]  t_res_list;
    typedef t_res [MUTE_LEN-1:0] t_mute_list;

    typedef struct packed {
        t_res_list        list;
        logic [CNT_W-1:0] count;
    } t_batch;

    typedef struct packed {
        logic [6:0] fm_mask;
        logic [3:0] psg_mask;
        logic       fix_psg;
        logic       mit_trim;
        logic       mono;
    } t_cfg;

    typedef struct packed {
        logic [5:0][7:0] pans;
        logic [3:0][7:0] atten;
        logic            dac;
        logic            bfw;
    } t_play;

    function automatic logic [7:0] psg_off(input logic [1:0] ch);
        return PSG_OFF | {1'b0, ch, 5'd0};
    endfunction

    function automatic t_play play_reset();
        t_play p;
        for (int i = 0; i < 6; i++) p.pans[i] = PAN_SIDES;
        for (int i = 0; i < 4; i++) p.atten[i] = psg_off(2'(i));
        p.dac = 1'b0;
        p.bfw = 1'b1;
        return p;
    endfunction

    function automatic logic [7:0] mask_pan(input logic [7:0] pan, input logic audible,
                                            input logic mono);
        logic [7:0] r;
        r = pan;
        if (!audible) r = r & PAN_KEEP;
        if (mono && ((r & PAN_SIDES) != 8'd0)) r = r | PAN_SIDES;
        return r;
    endfunction

    function automatic t_res fm_op(input logic port, input logic [7:0] addr,
                                   input logic [7:0] val);
        t_res r;
        r = '0;
        r.kind    = KIND_FM;
        r.fm_port = port;
        r.address = addr;
        r.value   = val;
        return r;
    endfunction

    function automatic t_res psg_op(input logic [7:0] val);
        t_res r;
        r = '0;
        r.kind  = KIND_PSG;
        r.value = val;
        return r;
    endfunction

    function automatic t_res wait_op(input logic [15:0] amount);
        t_res r;
        r = '0;
        r.kind         = KIND_WAIT;
        r.wait_samples = amount;
        return r;
    endfunction

    // six pan writes then four psg attenuation writes
    function automatic t_mute_list mute_pass(input t_play st, input logic trim,
                                             input t_cfg cfg);
        t_mute_list l;
        logic       aud;
        for (int i = 0; i < 6; i++) begin
            if (i == 5) aud = st.dac ? cfg.fm_mask[6] : cfg.fm_mask[5];
            else aud = cfg.fm_mask[i];
            l[i] = fm_op(i >= 3, PAN_ADDR[i],
                         trim ? (st.pans[i] & PAN_KEEP) : mask_pan(st.pans[i], aud, cfg.mono));
        end
        for (int i = 0; i < 4; i++) begin
            l[6+i] = psg_op((trim || !cfg.psg_mask[i]) ? psg_off(2'(i)) : st.atten[i]);
        end
        return l;
    endfunction

endpackage

[hdl/vgmci_stream_if.sv]
// valid/ready stream channel carrying one payload item
`timescale 1ns / 1ps
interface vgmci_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/vgm_command_interpreter_with_muting.sv]
// top level of the vgm command interpreter with channel muting
// a command transfer is registered in the input register, expanded combinationally once
//   the result buffer can take it, and then loaded into the result buffer
// the result buffer offers one result per cycle while the sink is ready; a command
//   yields up to 12 results, for a dac write with the first nonzero wait
// reset: synchronous active low; restores register defaults and the playback state
`timescale 1ns / 1ps
module vgm_command_interpreter_with_muting
    import vgmci_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    vgmci_stream_if.sink         i_cmd,
    vgmci_stream_if.source       o_res
);
    t_cmd   r_in;
    logic   r_in_valid;
    t_cfg   w_cfg;
    t_batch w_batch;
    logic   w_load_ready;
    logic   w_take;
    logic   w_in_xfer;

    assign w_take      = r_in_valid && w_load_ready;
    assign i_cmd.ready = !r_in_valid || w_take;
    assign w_in_xfer   = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_xfer || (r_in_valid && !w_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_cmd.data;
        end
    end

    vgmci_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    vgmci_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_cmd   (r_in),
        .i_cfg   (w_cfg),
        .o_batch (w_batch)
    );

    vgmci_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_take),
        .i_batch      (w_batch),
        .o_load_ready (w_load_ready),
        .o_res        (o_res)
    );
endmodule

[hdl/vgmci_cfg.sv]
// configuration registers with their reset defaults
`timescale 1ns / 1ps
module vgmci_cfg
    import vgmci_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);
    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FM_MASK:  n_cfg.fm_mask  = i_cfg_wdata;
                CFG_PSG_MASK: n_cfg.psg_mask = i_cfg_wdata[3:0];
                CFG_FIX_PSG:  n_cfg.fix_psg  = i_cfg_wdata[0];
                CFG_MIT_TRIM: n_cfg.mit_trim = i_cfg_wdata[0];
                CFG_MONO:     n_cfg.mono     = i_cfg_wdata[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fm_mask  <= 7'h7F;
            r_cfg.psg_mask <= 4'hF;
            r_cfg.fix_psg  <= 1'b1;
            r_cfg.mit_trim <= 1'b1;
            r_cfg.mono     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

[hdl/vgmci_decode.sv]
// playback state and expansion of one command into its list of bus operations
`timescale 1ns / 1ps
module vgmci_decode
    import vgmci_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_cmd   i_cmd,
    input  t_cfg   i_cfg,
    output t_batch o_batch
);
    t_play      r_play;
    t_play      n_play;
    logic [7:0] r_hold;
    logic [7:0] n_hold;

    t_play      m_play;
    logic       m_trim;
    logic       w_trim;
    t_mute_list w_mute;

    assign w_trim = i_cfg.mit_trim & r_play.bfw;

    // state and trim flag seen by the muting pass of this item
    always_comb begin
        m_play = r_play;
        case (i_cmd.action)
            ACT_START: begin
                m_play = play_reset();
                m_trim = i_cfg.mit_trim;
            end
            ACT_REFRESH: m_trim = w_trim;
            ACT_SILENCE: m_trim = 1'b1;
            default:     m_trim = 1'b0;
        endcase
    end

    assign w_mute = mute_pass(m_play, m_trim, i_cfg);

    always_comb begin
        t_res_list        v_list;
        logic [CNT_W-1:0] v_n;
        logic [7:0]       v_op;
        logic [7:0]       v_d;
        logic [2:0]       v_ch;
        logic             v_port;
        logic             v_aud;
        logic [7:0]       v_w;
        logic [15:0]      v_amt;
        logic             v_is_wait;
        logic             v_dacw;
        logic [CNT_W-1:0] v_base;

        v_list    = '0;
        v_n       = '0;
        n_play    = r_play;
        n_hold    = r_hold;
        v_op      = i_cmd.opcode;
        v_d       = i_cmd.data_lo;
        v_ch      = '0;
        v_port    = v_op[0];
        v_aud     = 1'b0;
        v_w       = i_cmd.data_hi;
        v_amt     = '0;
        v_is_wait = 1'b0;
        v_dacw    = 1'b0;
        v_base    = '0;

        case (i_cmd.action)
            ACT_START, ACT_REFRESH, ACT_SILENCE: begin
                if (i_cmd.action == ACT_START) n_play = play_reset();
                for (int i = 0; i < MUTE_LEN; i++) v_list[i] = w_mute[i];
                v_n = CNT_W'(MUTE_LEN);
            end
            default: begin
                if (v_op == OP_PSG) begin
                    if (!i_cfg.fix_psg) begin
                        v_list[0] = psg_op(v_d);
                        v_n = CNT_W'(1);
                    end else if (!v_d[7]) begin
                        // an all-zero frequency becomes one
                        if (r_hold[3:0] == 4'd0 && v_d[5:0] == 6'd0) n_hold[0] = 1'b1;
                        v_list[0] = psg_op(n_hold);
                        v_list[1] = psg_op(v_d);
                        v_n = CNT_W'(2);
                    end else if (!v_d[4] && v_d[6:5] != 2'b11) begin
                        n_hold = v_d;
                    end else begin
                        if ((v_d & PSG_ATT) == PSG_ATT) begin
                            n_play.atten[v_d[6:5]] = v_d;
                            if (w_trim || !i_cfg.psg_mask[v_d[6:5]]) v_d[3:0] = 4'hF;
                        end
                        v_list[0] = psg_op(v_d);
                        v_n = CNT_W'(1);
                    end
                end else if (v_op == OP_FM0 || v_op == OP_FM1) begin
                    if (v_d >= REG_PAN1 && v_d <= REG_PAN3) begin
                        v_ch = v_port ? 3'(v_d[1:0]) + 3'd3 : 3'(v_d[1:0]);
                        n_play.pans[v_ch] = i_cmd.data_hi;
                        if (v_ch == 3'd5)
                            v_aud = r_play.dac ? i_cfg.fm_mask[6] : i_cfg.fm_mask[5];
                        else
                            v_aud = i_cfg.fm_mask[v_ch];
                        if (w_trim) v_w = v_w & PAN_KEEP;
                        v_w = mask_pan(v_w, v_aud, i_cfg.mono);
                    end
                    if (!v_port && v_d == REG_DACEN && i_cmd.data_hi[7] != r_play.dac) begin
                        // dac toggle moves channel six onto the other mask bit
                        n_play.dac = i_cmd.data_hi[7];
                        v_aud = i_cmd.data_hi[7] ? i_cfg.fm_mask[6] : i_cfg.fm_mask[5];
                        v_list[0] = fm_op(1'b1, REG_PAN3, w_trim ? (r_play.pans[5] & PAN_KEEP)
                                          : mask_pan(r_play.pans[5], v_aud, i_cfg.mono));
                        v_list[1] = fm_op(v_port, v_d, v_w);
                        v_n = CNT_W'(2);
                    end else begin
                        v_list[0] = fm_op(v_port, v_d, v_w);
                        v_n = CNT_W'(1);
                    end
                end else if (v_op == OP_WAIT) begin
                    v_is_wait = 1'b1;
                    v_amt = {i_cmd.data_hi, i_cmd.data_lo};
                end else if (v_op == OP_WAIT_NTSC) begin
                    v_is_wait = 1'b1;
                    v_amt = WAIT_NTSC;
                end else if (v_op == OP_WAIT_PAL) begin
                    v_is_wait = 1'b1;
                    v_amt = WAIT_PAL;
                end else if (v_op[7:4] == OP_HI_WAITN) begin
                    v_is_wait = 1'b1;
                    v_amt = 16'(v_op[3:0]) + 16'd1;
                end else if (v_op[7:4] == OP_HI_DACW) begin
                    v_is_wait = 1'b1;
                    v_dacw = 1'b1;
                    v_amt = 16'(v_op[3:0]);
                end else if ((v_op >= OP_STRM_LO && v_op <= OP_STRM_HI) || v_op == OP_GG
                             || v_op == OP_PWM) begin
                    v_n = '0;
                end else if (v_op == OP_END) begin
                    for (int i = 0; i < 4; i++) v_list[i] = psg_op(psg_off(2'(i)));
                    v_list[4] = '0;
                    v_list[4].kind = KIND_RESET;
                    v_n = CNT_W'(5);
                end else begin
                    v_list[0] = '0;
                    v_list[0].kind = KIND_UNKNOWN;
                    v_list[0].value = v_op;
                    v_n = CNT_W'(1);
                end

                if (v_is_wait) begin
                    if (v_dacw) begin
                        v_list[0] = fm_op(1'b0, REG_DAC, i_cmd.pcm_sample);
                        v_base = CNT_W'(1);
                    end
                    // first nonzero wait unmutes: pass runs with trim already off
                    if (v_amt != 16'd0 && r_play.bfw) begin
                        n_play.bfw = 1'b0;
                        for (int i = 0; i < MUTE_LEN; i++)
                            v_list[v_base + CNT_W'(i)] = w_mute[i];
                        v_list[v_base + CNT_W'(MUTE_LEN)] = wait_op(v_amt);
                        v_n = v_base + CNT_W'(MUTE_LEN + 1);
                    end else begin
                        v_list[v_base] = wait_op(v_amt);
                        v_n = v_base + CNT_W'(1);
                    end
                end
            end
        endcase

        o_batch.list  = v_list;
        o_batch.count = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play <= play_reset();
            r_hold <= '0;
        end else if (i_take) begin
            r_play <= n_play;
            r_hold <= n_hold;
        end
    end
endmodule

[hdl/vgmci_emit.sv]
// result buffer that sends a command's bus operations one transfer at a time
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vgmci_emit
    import vgmci_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_batch i_batch,
    output logic   o_load_ready,
    vgmci_stream_if.source o_res
);
    t_res_list        r_list;
    logic [CNT_W-1:0] r_left;
    logic             r_busy;

    logic w_xfer;
    logic w_last;

    assign w_xfer       = r_busy && o_res.ready;
    assign w_last       = (r_left == CNT_W'(1));
    assign o_load_ready = !r_busy || (w_xfer && w_last);

    always_comb begin
        o_res.valid     = r_busy;
        o_res.data      = r_list[0];
        o_res.data.last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_busy <= (i_batch.count != '0);
            r_left <= i_batch.count;
        end else if (w_xfer) begin
            r_busy <= !w_last;
            r_left <= r_left - CNT_W'(1);
        end
    end

    // payload shifts toward the head on each transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_list <= i_batch.list;
        end else if (w_xfer) begin
            for (int i = 0; i < MAX_RES - 1; i++) r_list[i] <= r_list[i+1];
            r_list[MAX_RES-1] <= '0;
        end
    end

    `VGM_ASSERT_NEVER(a_busy_empty, i_clk, i_rst_n, r_busy && (r_left == '0))
    `VGM_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load |-> o_load_ready)
    `VGM_ASSERT(a_burst_holds, i_clk, i_rst_n, (w_xfer && !w_last) |=> r_busy)
    `VGM_ASSERT(a_load_count, i_clk, i_rst_n, (i_load && (i_batch.count != '0)) |=> (r_busy && (r_left == $past(i_batch.count))))
endmodule
